// ===== rtl/core/dq_pkg.sv =====
// dq_pkg: shared constants and codes for the double-ended queue
// operation codes, status codes and default sizes; no dependencies
`timescale 1ns / 1ps

package dq_pkg;

    // entry width and default ring depth
    localparam int DQ_WIDTH = 32;
    localparam int DQ_DEPTH = 32;

    // request operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_DISPLAY    = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// ===== rtl/core/dq_ram.sv =====
// dq_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// double_ended_queue: bounded deque of signed values kept in a ring ram
// depends on dq_pkg and dq_ram
// a push or pop result goes through S_RES into the output register once that is free;
// the block holds stall until its last result is registered, taking no request before.
// display emits count results, one per cycle unless stalled, or one empty status if empty.
// a stalled result holds the block; synchronous active-low reset clears front, count, control.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_op,
    input  logic signed [dq_pkg::DQ_WIDTH-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [dq_pkg::DQ_WIDTH-1:0] o_value_res,
    output logic [1:0]                        o_status,
    output logic                              o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int VW = dq_pkg::DQ_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RES  = 3'b010,
        S_WALK = 3'b100
    } t_state;

    // ring index helpers
    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_offset(input logic [IW-1:0] idx,
                                                  input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(idx) + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [IW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_slot, n_slot;
    logic [CW-1:0]   r_left, n_left;
    logic signed [VW-1:0] r_res_value, n_res_value;
    dq_pkg::t_status r_res_status, n_res_status;
    logic            r_use_mem, n_use_mem;
    logic            r_out_valid, n_out_valid;
    logic signed [VW-1:0] r_out_value, n_out_value;
    dq_pkg::t_status r_out_status, n_out_status;
    logic            r_out_last, n_out_last;

    logic            accept;
    logic            out_free;
    logic            is_full;
    logic            is_empty;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic [VW-1:0]   rd_data;

    // entry store
    dq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // handshake
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // request decode, ram access and result sequencing
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_slot       = r_slot;
        n_left       = r_left;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_use_mem    = r_use_mem;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = r_front;
        rd_en        = 1'b0;
        rd_addr      = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_value  = i_value;
                    n_res_status = dq_pkg::ST_OK;
                    n_use_mem    = 1'b0;
                    unique case (dq_pkg::t_op'(i_op))
                        dq_pkg::OP_PUSH_FRONT: begin
                            n_state = S_RES;
                            if (is_full) begin
                                n_res_status = dq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = ring_prev(r_front);
                                n_front = ring_prev(r_front);
                                n_count = r_count + 1'b1;
                            end
                        end
                        dq_pkg::OP_PUSH_REAR: begin
                            n_state = S_RES;
                            if (is_full) begin
                                n_res_status = dq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = ring_offset(r_front, r_count);
                                n_count = r_count + 1'b1;
                            end
                        end
                        dq_pkg::OP_POP_FRONT: begin
                            n_state = S_RES;
                            if (is_empty) begin
                                n_res_value  = '0;
                                n_res_status = dq_pkg::ST_EMPTY;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = r_front;
                                n_use_mem = 1'b1;
                                n_front   = ring_next(r_front);
                                n_count   = r_count - 1'b1;
                            end
                        end
                        dq_pkg::OP_POP_REAR: begin
                            n_state = S_RES;
                            if (is_empty) begin
                                n_res_value  = '0;
                                n_res_status = dq_pkg::ST_EMPTY;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = ring_offset(r_front, r_count - 1'b1);
                                n_use_mem = 1'b1;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        dq_pkg::OP_DISPLAY: begin
                            if (is_empty) begin
                                n_state      = S_RES;
                                n_res_value  = '0;
                                n_res_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_WALK;
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_slot  = ring_next(r_front);
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            // unused codes give no result
                        end
                    endcase
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_use_mem ? $signed(rd_data) : r_res_value;
                    n_out_status = r_res_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                // emit current entry, then fetch the next one
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = $signed(rd_data);
                    n_out_status = dq_pkg::ST_OK;
                    n_out_last   = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_slot;
                        n_slot  = ring_next(r_slot);
                        n_left  = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_left       <= n_left;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_use_mem    <= n_use_mem;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule
